FILE: hw/rtl/tcra_pkg.sv
// ----------------------------------------------------------------------------
// tcra_pkg
// Shared constants, pipeline item type and core type helpers for the typed
// core remap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tcra_pkg;

    localparam int NUM_CORES    = 16;
    localparam int TYPE_BITS    = 2;
    localparam int CORE_W       = 4;
    localparam int MAP_W        = 32;
    localparam int COUNT_W      = 5;
    localparam int MASK_W       = 16;
    localparam int TARGET_W     = 64;
    localparam int STEPS        = 4;
    localparam int ALLOC_STAGES = (NUM_CORES + STEPS - 1) / STEPS;
    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 88;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_CORE_TYPE_MAP = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CORE_COUNT    = 1'b1;

    localparam logic [COUNT_W-1:0] CORE_COUNT_RESET = COUNT_W'(16);

    typedef struct packed {
        logic [NUM_CORES-1:0]        pending;
        logic [NUM_CORES-1:0]        free;
        logic [NUM_CORES-1:0]        moved;
        logic [NUM_CORES*CORE_W-1:0] targets;
        logic                        fail;
    } item_t;

    // type code of one core, zero where its field lies beyond the map
    function automatic logic [TYPE_BITS-1:0] type_of(input logic [MAP_W-1:0] map,
                                                    input int core);
        logic [TYPE_BITS-1:0] r;
        r = '0;
        if (core * TYPE_BITS < MAP_W)
        begin
            r = TYPE_BITS'(map >> (core * TYPE_BITS));
        end
        return r;
    endfunction

    // mask of all cores of one type
    function automatic logic [NUM_CORES-1:0] type_cores(input logic [MAP_W-1:0] map,
                                                       input logic [TYPE_BITS-1:0] t);
        logic [NUM_CORES-1:0] m;
        m = '0;
        for (int c = 0; c < NUM_CORES; c++)
        begin
            m[c] = (type_of(map, c) == t);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcra_prep.sv
// ----------------------------------------------------------------------------
// tcra_prep
// Entry stage: masks the request by the present cores, keeps free requested
// cores in place and registers the item for the allocation chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tcra_prep
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tcra_pkg::COUNT_W-1:0]   core_count,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tcra_pkg::MASK_W-1:0]    request_mask,
    input  wire logic [tcra_pkg::MASK_W-1:0]    busy_mask,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output tcra_pkg::item_t                    out_item
);

    logic [tcra_pkg::NUM_CORES-1:0] present;
    logic [tcra_pkg::NUM_CORES-1:0] req;
    logic [tcra_pkg::NUM_CORES-1:0] free_in;
    logic [tcra_pkg::NUM_CORES-1:0] stay;
    logic                           valid_reg;
    logic                           valid_next;
    tcra_pkg::item_t                item_reg;
    tcra_pkg::item_t                item_next;

    always_comb
    begin
        for (int c = 0; c < tcra_pkg::NUM_CORES; c++)
        begin
            present[c] = (tcra_pkg::COUNT_W'(c) < core_count);
        end
        req     = tcra_pkg::NUM_CORES'(request_mask) & present;
        free_in = ~tcra_pkg::NUM_CORES'(busy_mask) & present;
        stay    = req & free_in;

        item_next.pending = req & ~stay;
        item_next.free    = free_in & ~stay;
        item_next.moved   = '0;
        item_next.fail    = 1'b0;
        item_next.targets = '0;
        for (int c = 0; c < tcra_pkg::NUM_CORES; c++)
        begin
            if (stay[c])
            begin
                item_next.targets[c*tcra_pkg::CORE_W +: tcra_pkg::CORE_W] =
                    tcra_pkg::CORE_W'(c);
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tcra_alloc_stage.sv
// ----------------------------------------------------------------------------
// tcra_alloc_stage
// One allocation stage: serves the next few pending cores in ascending order,
// each taking the lowest free core of its own type.
// ----------------------------------------------------------------------------
`default_nettype none

module tcra_alloc_stage
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tcra_pkg::MAP_W-1:0]     core_type_map,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire tcra_pkg::item_t               in_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output tcra_pkg::item_t                    out_item
);

    logic                           hit;
    logic [tcra_pkg::CORE_W-1:0]    idx;
    logic [tcra_pkg::CORE_W-1:0]    sel;
    logic [tcra_pkg::NUM_CORES-1:0] cand;
    logic                           valid_reg;
    logic                           valid_next;
    tcra_pkg::item_t                item_reg;
    tcra_pkg::item_t                item_next;

    always_comb
    begin
        item_next = in_item;
        hit       = 1'b0;
        idx       = '0;
        sel       = '0;
        cand      = '0;
        for (int s = 0; s < tcra_pkg::STEPS; s++)
        begin
            // lowest pending core
            hit = 1'b0;
            idx = '0;
            for (int c = tcra_pkg::NUM_CORES - 1; c >= 0; c--)
            begin
                if (item_next.pending[c])
                begin
                    hit = 1'b1;
                    idx = tcra_pkg::CORE_W'(c);
                end
            end
            // lowest free core of the same type
            cand = item_next.free & tcra_pkg::type_cores(core_type_map,
                       tcra_pkg::type_of(core_type_map, int'(idx)));
            sel = '0;
            for (int c = tcra_pkg::NUM_CORES - 1; c >= 0; c--)
            begin
                if (cand[c])
                begin
                    sel = tcra_pkg::CORE_W'(c);
                end
            end
            if (hit)
            begin
                item_next.pending[idx] = 1'b0;
                if (cand == '0)
                begin
                    item_next.fail = 1'b1;
                end
                else
                begin
                    item_next.free[sel] = 1'b0;
                    item_next.moved[idx] = 1'b1;
                    item_next.targets[int'(idx)*tcra_pkg::CORE_W +: tcra_pkg::CORE_W] = sel;
                end
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/typed_core_remap_allocator_core.sv
// ----------------------------------------------------------------------------
// typed_core_remap_allocator_core
// Relocates a set of requested cores onto free cores of the same type.
//
// channel   dir  tdata fields (lsb first)                      tuser/tlast
// s_axis    in   request_mask[15:0], busy_mask[15:0]           none
// m_axis    out  success, target_map[63:0], moved_mask[15:0]   none
// cfg       in   index 0 core_type_map, index 1 core_count     write only
//
// one transfer per cycle sustained while m_axis_tready is high; entry stage plus four
// allocation stages of four cores each, the last stage is the output register
// reset clears all stage valid bits, core_type_map to 0 and core_count to 16
// each stage holds when its successor is full and stalled; bubbles close up
// ----------------------------------------------------------------------------
`default_nettype none

module typed_core_remap_allocator_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tcra_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [tcra_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // request_mask[15:0], busy_mask[31:16]
    input  wire logic [tcra_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // success[0], target_map[64:1], moved_mask[80:65], zero fill above
    output logic [tcra_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    localparam int NS = tcra_pkg::ALLOC_STAGES;

    logic [tcra_pkg::MAP_W-1:0]   core_type_map_reg;
    logic [tcra_pkg::COUNT_W-1:0] core_count_reg;

    logic [NS:0]     stage_valid;
    logic [NS:0]     stage_ready;
    tcra_pkg::item_t stage_item [NS+1];
    tcra_pkg::item_t last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_type_map_reg <= '0;
            core_count_reg    <= tcra_pkg::CORE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tcra_pkg::REG_CORE_TYPE_MAP:
                begin
                    core_type_map_reg <= cfg_wdata;
                end
                tcra_pkg::REG_CORE_COUNT:
                begin
                    core_count_reg <= cfg_wdata[tcra_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    core_count_reg <= core_count_reg;
                end
            endcase
        end
    end

    tcra_prep u_prep
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .core_count   (core_count_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .request_mask (s_axis_tdata[tcra_pkg::MASK_W-1:0]),
        .busy_mask    (s_axis_tdata[2*tcra_pkg::MASK_W-1:tcra_pkg::MASK_W]),
        .out_valid    (stage_valid[0]),
        .out_ready    (stage_ready[0]),
        .out_item     (stage_item[0])
    );

    for (genvar k = 0; k < NS; k++)
    begin : g_alloc
        tcra_alloc_stage u_stage
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .core_type_map (core_type_map_reg),
            .in_valid      (stage_valid[k]),
            .in_ready      (stage_ready[k]),
            .in_item       (stage_item[k]),
            .out_valid     (stage_valid[k+1]),
            .out_ready     (stage_ready[k+1]),
            .out_item      (stage_item[k+1])
        );
    end

    assign stage_ready[NS] = m_axis_tready;
    assign last_item       = stage_item[NS];
    assign m_axis_tvalid   = stage_valid[NS];

    always_comb
    begin
        m_axis_tdata    = '0;
        m_axis_tdata[0] = !last_item.fail;
        if (!last_item.fail)
        begin
            m_axis_tdata[tcra_pkg::TARGET_W:1] = tcra_pkg::TARGET_W'(last_item.targets);
            m_axis_tdata[tcra_pkg::TARGET_W+tcra_pkg::MASK_W:tcra_pkg::TARGET_W+1] =
                tcra_pkg::MASK_W'(last_item.moved);
        end
    end

    // every pending core must be served by the end of the chain
    a_all_served: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[NS] |-> (last_item.pending == '0))
        else $error("pending core left after last allocation stage");

    // a core waiting for a target is never itself free
    a_pending_not_free: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[0] |-> ((stage_item[0].pending & stage_item[0].free) == '0))
        else $error("pending core marked free after entry stage");

    // a moved core was never in the free set at entry and is no longer pending at the end
    a_moved_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[NS] |-> ((last_item.moved & last_item.pending) == '0))
        else $error("moved core still pending");

endmodule

`default_nettype wire

FILE: dv/tcra_remap_checker.sv
// ----------------------------------------------------------------------------
// tcra_remap_checker
// Watches the request, result and register write channels of the typed core
// remap allocator. Keeps its own copy of the type map and core count, works
// out the expected remapping for every accepted request and compares each
// result transfer field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcra_remap_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [tcra_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [tcra_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    // request_mask[15:0], busy_mask[31:16]
    input  wire logic [tcra_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // success[0], target_map[64:1], moved_mask[80:65], zero fill above
    input  wire logic [tcra_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                                   failures,
    output int                                   outstanding
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic                          success;
        logic [tcra_pkg::TARGET_W-1:0] target_map;
        logic [tcra_pkg::MASK_W-1:0]   moved_mask;
    } remap_t;

    logic [tcra_pkg::MAP_W-1:0]   type_map;
    logic [tcra_pkg::COUNT_W-1:0] core_total;
    remap_t                       expected_remaps[$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what,
                                   input logic [tcra_pkg::TARGET_W-1:0] got,
                                   input logic [tcra_pkg::TARGET_W-1:0] want);
        if (failures < PRINT_LIMIT)
        begin
            $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
        end
        failures++;
    endtask

    function automatic remap_t predict_remap(input logic [tcra_pkg::MASK_W-1:0] request,
                                             input logic [tcra_pkg::MASK_W-1:0] busy);
        remap_t                      r;
        logic [tcra_pkg::MASK_W-1:0] req;
        logic [tcra_pkg::MASK_W-1:0] free_set;
        logic [tcra_pkg::MASK_W-1:0] pending;
        int                          n;
        bit                          found;
        r        = '0;
        req      = '0;
        free_set = '0;
        n        = (core_total > tcra_pkg::NUM_CORES) ? tcra_pkg::NUM_CORES
                                                      : int'(core_total);
        for (int c = 0; c < n; c++)
        begin
            req[c]      = request[c];
            free_set[c] = !busy[c];
        end
        pending = req;
        // requested cores that are free stay where they are
        for (int c = 0; c < n; c++)
        begin
            if (req[c] && free_set[c])
            begin
                r.target_map[c*tcra_pkg::CORE_W +: tcra_pkg::CORE_W] = tcra_pkg::CORE_W'(c);
                free_set[c] = 1'b0;
                pending[c]  = 1'b0;
            end
        end
        // the rest take the lowest free core of the same type, in core order
        for (int c = 0; c < n; c++)
        begin
            if (pending[c])
            begin
                found = 1'b0;
                for (int t = 0; t < n && !found; t++)
                begin
                    if (free_set[t] &&
                        type_map[t*tcra_pkg::TYPE_BITS +: tcra_pkg::TYPE_BITS] ==
                        type_map[c*tcra_pkg::TYPE_BITS +: tcra_pkg::TYPE_BITS])
                    begin
                        r.target_map[c*tcra_pkg::CORE_W +: tcra_pkg::CORE_W] =
                            tcra_pkg::CORE_W'(t);
                        free_set[t] = 1'b0;
                        if (t != c)
                        begin
                            r.moved_mask[c] = 1'b1;
                        end
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    return '0;
                end
            end
        end
        r.success = 1'b1;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        remap_t got;
        remap_t want;
        if (!rst_n)
        begin
            type_map   = '0;
            core_total = tcra_pkg::CORE_COUNT_RESET;
            expected_remaps.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.success    = m_axis_tdata[0];
                got.target_map = m_axis_tdata[tcra_pkg::TARGET_W:1];
                got.moved_mask =
                    m_axis_tdata[tcra_pkg::TARGET_W+tcra_pkg::MASK_W:tcra_pkg::TARGET_W+1];
                if (expected_remaps.size() == 0)
                begin
                    report_mismatch("result with nothing expected",
                                    tcra_pkg::TARGET_W'(got), '0);
                end
                else
                begin
                    want = expected_remaps.pop_front();
                    if (got.success !== want.success)
                    begin
                        report_mismatch("success", tcra_pkg::TARGET_W'(got.success),
                                        tcra_pkg::TARGET_W'(want.success));
                    end
                    if (got.target_map !== want.target_map)
                    begin
                        report_mismatch("target_map", got.target_map, want.target_map);
                    end
                    if (got.moved_mask !== want.moved_mask)
                    begin
                        report_mismatch("moved_mask", tcra_pkg::TARGET_W'(got.moved_mask),
                                        tcra_pkg::TARGET_W'(want.moved_mask));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_remaps.push_back(predict_remap(
                    s_axis_tdata[tcra_pkg::MASK_W-1:0],
                    s_axis_tdata[2*tcra_pkg::MASK_W-1:tcra_pkg::MASK_W]));
            end
            if (cfg_we)
            begin
                if (cfg_addr == tcra_pkg::REG_CORE_TYPE_MAP)
                begin
                    type_map = cfg_wdata[tcra_pkg::MAP_W-1:0];
                end
                else if (cfg_addr == tcra_pkg::REG_CORE_COUNT)
                begin
                    core_total = cfg_wdata[tcra_pkg::COUNT_W-1:0];
                end
            end
        end
        outstanding <= expected_remaps.size();
    end

endmodule

FILE: dv/tb_typed_core_remap_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_typed_core_remap_allocator_core
// Drives requests into the typed core remap allocator under several type maps
// and core counts: directed corner requests, then random phases with random
// stalls on both sides (none in the calm last one) and two long receiver
// hold-offs. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_typed_core_remap_allocator_core;

    localparam int LATENCY        = 5;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_REQUESTS = 140;

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [tcra_pkg::CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [tcra_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tcra_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tcra_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    int failures;
    int outstanding;
    bit calm     = 1'b0;
    bit gaps_on  = 1'b1;
    bit hold_now = 1'b0;

    typed_core_remap_allocator_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tcra_remap_checker remap_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(input logic [tcra_pkg::MASK_W-1:0] request,
                                input logic [tcra_pkg::MASK_W-1:0] busy);
        if (!calm && gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {busy, request};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic apply_config(input logic [tcra_pkg::MAP_W-1:0] type_map,
                                input logic [tcra_pkg::CFG_DATA_W-1:0] count_word);
        cfg_we    <= 1'b1;
        cfg_addr  <= tcra_pkg::REG_CORE_TYPE_MAP;
        cfg_wdata <= tcra_pkg::CFG_DATA_W'(type_map);
        @(posedge clk);
        cfg_addr  <= tcra_pkg::REG_CORE_COUNT;
        cfg_wdata <= count_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_request();
        logic [tcra_pkg::MASK_W-1:0] request;
        logic [tcra_pkg::MASK_W-1:0] busy;
        case ($urandom_range(0, 5))
            0:
            begin
                request = tcra_pkg::MASK_W'($urandom);
                busy    = tcra_pkg::MASK_W'($urandom);
            end
            1:
            begin
                request = tcra_pkg::MASK_W'($urandom & $urandom);
                busy    = tcra_pkg::MASK_W'($urandom & $urandom & $urandom);
            end
            2:
            begin
                request = tcra_pkg::MASK_W'($urandom | $urandom);
                busy    = tcra_pkg::MASK_W'($urandom & $urandom);
            end
            3:
            begin
                // every requested core busy, so all of them have to move
                request = tcra_pkg::MASK_W'($urandom & $urandom);
                busy    = tcra_pkg::MASK_W'($urandom) | request;
            end
            4:
            begin
                request = ($urandom_range(0, 1) == 0) ? '1 : '0;
                busy    = tcra_pkg::MASK_W'($urandom);
            end
            default:
            begin
                request = tcra_pkg::MASK_W'($urandom & $urandom);
                busy    = tcra_pkg::MASK_W'($urandom & $urandom);
            end
        endcase
        send_request(request, busy);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_now)
            begin
                hold_now = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (calm || $urandom_range(0, 3) != 0)
            begin
                m_axis_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [tcra_pkg::MAP_W-1:0]      type_map;
        logic [tcra_pkg::CFG_DATA_W-1:0] count_word;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one type, sixteen cores
        send_request(16'h0000, 16'h0000);
        send_request(16'hffff, 16'h0000);
        send_request(16'hffff, 16'hffff);
        send_request(16'h0001, 16'h0001);
        send_request(16'hffff, 16'h0001);
        send_request(16'h8000, 16'h7fff);
        send_request(16'h0001, 16'hfffe);
        wait_drained();

        // four types interleaved
        apply_config(32'he4e4e4e4, 32'd16);
        send_request(16'h000f, 16'h000f);
        send_request(16'h0001, 16'hffef);
        send_request(16'h0002, 16'hffff);
        send_request(16'haaaa, 16'h5555);
        send_request(16'h00ff, 16'h0f0f);
        wait_drained();

        // no cores present
        apply_config(32'hffffffff, 32'd0);
        send_request(16'hffff, 16'hffff);
        send_request(16'hffff, 16'h0000);
        wait_drained();

        // counts above sixteen saturate
        apply_config(32'h00000000, 32'hffffffff);
        send_request(16'hffff, 16'h0000);
        send_request(16'h0001, 16'h0001);
        wait_drained();
        apply_config(32'h00000000, 32'd17);
        send_request(16'h8000, 16'h8000);
        wait_drained();

        // single core, request and busy bits above it ignored
        apply_config(32'hffffffff, 32'hffffffe1);
        send_request(16'hffff, 16'h0000);
        send_request(16'h0001, 16'h0001);
        send_request(16'hfffe, 16'hfffe);
        wait_drained();
        apply_config(32'h000003c0, 32'd5);
        send_request(16'h001f, 16'h0000);
        send_request(16'hffff, 16'hfff0);
        send_request(16'h0018, 16'hffe7);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       type_map = $urandom;
                1:       type_map = '0;
                2:       type_map = '1;
                default: type_map = $urandom & 32'h55555555;
            endcase
            count_word = $urandom & ~32'h1f;
            case ($urandom_range(0, 4))
                0, 1, 2: count_word = count_word | 32'd16;
                3:       count_word = count_word | $urandom_range(0, 31);
                default: count_word = count_word | $urandom_range(1, 4);
            endcase
            apply_config(type_map, count_word);
            calm    = (phase == RANDOM_PHASES - 1);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 1 || phase == 6)
            begin
                hold_now = 1'b1;
            end
            repeat (PHASE_REQUESTS) send_random_request();
            wait_drained();
        end

        repeat (4 * LATENCY) @(posedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tcra_pkg.sv
hw/rtl/tcra_prep.sv
hw/rtl/tcra_alloc_stage.sv
hw/rtl/typed_core_remap_allocator_core.sv
dv/tcra_remap_checker.sv
dv/tb_typed_core_remap_allocator_core.sv
